>>> rtl/pdvm_pkg.sv
// ----------------------------------------------------------------------------
// pdvm_pkg
// Shared types and constants for the perspective divide and viewport map.
// ----------------------------------------------------------------------------
package pdvm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int VP_W          = 14;
  localparam int SLOT_W        = 4;
  localparam int LANES         = 3;
  localparam int QCLAMP_LOG    = 48;
  localparam int QC_W          = QCLAMP_LOG + 2;

  typedef enum logic [1:0] {
    REG_MIN_X = 2'd0,
    REG_MIN_Y = 2'd1,
    REG_MAX_X = 2'd2,
    REG_MAX_Y = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] clip_x;
    logic signed [DATA_W-1:0] clip_y;
    logic signed [DATA_W-1:0] clip_z;
    logic signed [DATA_W-1:0] clip_w;
    logic [SLOT_W-1:0]        vertex_slot;
    logic                     last_vertex;
  } vtx_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] screen_x;
    logic signed [DATA_W-1:0] screen_y;
    logic signed [DATA_W-1:0] depth;
    logic                     fault;
    logic [SLOT_W-1:0]        slot_out;
    logic                     last_out;
  } vtx_out_t;

  typedef struct packed {
    logic                w_zero;
    logic [LANES-1:0]    num_neg;
    logic [LANES-1:0]    num_nz;
    logic                den_neg;
    logic [SLOT_W-1:0]   slot;
    logic                last;
  } side_t;

  typedef struct packed {
    logic signed [VP_W-1:0] min_x;
    logic signed [VP_W-1:0] min_y;
    logic signed [VP_W-1:0] max_x;
    logic signed [VP_W-1:0] max_y;
  } viewport_t;

endpackage

>>> rtl/pdvm_div_pipe.sv
// ----------------------------------------------------------------------------
// pdvm_div_pipe
// Pipelined restoring divider, three numerators over one shared divisor,
// two quotient bits per stage, sideband carried alongside.
// ----------------------------------------------------------------------------
module pdvm_div_pipe #(
  parameter int NW = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic [pdvm_pkg::LANES-1:0][NW-1:0] num,
  input  logic [pdvm_pkg::DATA_W-1:0]       den,
  input  pdvm_pkg::side_t                   side_in,
  output logic                              out_valid,
  output logic [pdvm_pkg::LANES-1:0][NW-1:0] quo,
  output pdvm_pkg::side_t                   side_out
);

  localparam int BPS = 2;
  localparam int S   = (NW + BPS - 1) / BPS;
  localparam int NP  = S * BPS;
  localparam int DW  = pdvm_pkg::DATA_W;

  logic                  v_s    [0:S];
  logic [NP-1:0]         nq_s   [0:S][pdvm_pkg::LANES];
  logic [DW-1:0]         rem_s  [0:S][pdvm_pkg::LANES];
  logic [DW-1:0]         den_s  [0:S];
  pdvm_pkg::side_t       side_s [0:S];

  assign v_s[0]    = in_valid;
  assign den_s[0]  = den;
  assign side_s[0] = side_in;

  for (genvar l = 0; l < pdvm_pkg::LANES; l++) begin : g_in
    assign nq_s[0][l]  = NP'(num[l]);
    assign rem_s[0][l] = '0;
  end

  for (genvar k = 0; k < S; k++) begin : g_stage
    logic [NP-1:0] nq_next  [pdvm_pkg::LANES];
    logic [DW-1:0] rem_next [pdvm_pkg::LANES];

    always_comb begin
      logic [DW:0] t;
      for (int l = 0; l < pdvm_pkg::LANES; l++) begin
        nq_next[l]  = nq_s[k][l];
        rem_next[l] = rem_s[k][l];
        for (int b = 0; b < BPS; b++) begin
          t = {rem_next[l], nq_next[l][NP-1]};
          if (t >= {1'b0, den_s[k]}) begin
            t = t - {1'b0, den_s[k]};
            nq_next[l] = {nq_next[l][NP-2:0], 1'b1};
          end else begin
            nq_next[l] = {nq_next[l][NP-2:0], 1'b0};
          end
          rem_next[l] = t[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (adv) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den_s[k+1]  <= den_s[k];
        side_s[k+1] <= side_s[k];
        for (int l = 0; l < pdvm_pkg::LANES; l++) begin
          nq_s[k+1][l]  <= nq_next[l];
          rem_s[k+1][l] <= rem_next[l];
        end
      end
    end
  end

  assign out_valid = v_s[S];
  assign side_out  = side_s[S];

  for (genvar l = 0; l < pdvm_pkg::LANES; l++) begin : g_out
    assign quo[l] = nq_s[S][l][NW-1:0];
  end

endmodule

>>> rtl/pdvm_map.sv
// ----------------------------------------------------------------------------
// pdvm_map
// Sign fix, clamp, viewport scale and translate, saturation. Three stages,
// the last one is the output register.
// ----------------------------------------------------------------------------
module pdvm_map #(
  parameter int FB = 16,
  parameter int NW = 48
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               in_valid,
  input  logic [pdvm_pkg::LANES-1:0][NW-1:0] quo,
  input  pdvm_pkg::side_t                    side,
  input  pdvm_pkg::viewport_t                vp,
  output logic                               out_valid,
  output pdvm_pkg::vtx_out_t                 out_data
);

  localparam int QC = pdvm_pkg::QC_W;
  localparam logic signed [63:0] QMAX = 64'sd1 <<< pdvm_pkg::QCLAMP_LOG;
  localparam logic signed [63:0] QMIN = -QMAX;
  localparam logic signed [63:0] SMAX = 64'sd2147483647;
  localparam logic signed [63:0] SMIN = -64'sd2147483648;

  logic signed [63:0] q [pdvm_pkg::LANES];

  always_comb begin
    logic neg;
    logic [63:0] mag;
    for (int l = 0; l < pdvm_pkg::LANES; l++) begin
      if (side.w_zero) begin
        neg = side.num_neg[l];
        mag = side.num_nz[l] ? 64'(QMAX) : 64'd0;
      end else begin
        neg = side.num_neg[l] ^ side.den_neg;
        mag = 64'(quo[l]);
      end
      q[l] = neg ? -$signed(mag) : $signed(mag);
    end
  end

  // clamp and depth saturation
  logic                         v1;
  logic signed [QC-1:0]         qx1, qy1;
  logic signed [pdvm_pkg::DATA_W-1:0] dep1;
  logic                         satz1;
  pdvm_pkg::side_t              side1;

  function automatic logic signed [QC-1:0] clampq(input logic signed [63:0] v);
    if (v > QMAX) begin
      return QC'(QMAX);
    end else if (v < QMIN) begin
      return QC'(QMIN);
    end
    return QC'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qx1   <= clampq(q[0]);
      qy1   <= clampq(q[1]);
      side1 <= side;
      if (q[2] > SMAX) begin
        dep1  <= pdvm_pkg::DATA_W'(SMAX);
        satz1 <= 1'b1;
      end else if (q[2] < SMIN) begin
        dep1  <= pdvm_pkg::DATA_W'(SMIN);
        satz1 <= 1'b1;
      end else begin
        dep1  <= pdvm_pkg::DATA_W'(q[2]);
        satz1 <= 1'b0;
      end
    end
  end

  // scale multiply
  logic signed [pdvm_pkg::VP_W:0] diff_x, diff_y, sum_x, sum_y;
  assign diff_x = (pdvm_pkg::VP_W+1)'(vp.max_x) - (pdvm_pkg::VP_W+1)'(vp.min_x);
  assign diff_y = (pdvm_pkg::VP_W+1)'(vp.max_y) - (pdvm_pkg::VP_W+1)'(vp.min_y);
  assign sum_x  = (pdvm_pkg::VP_W+1)'(vp.max_x) + (pdvm_pkg::VP_W+1)'(vp.min_x);
  assign sum_y  = (pdvm_pkg::VP_W+1)'(vp.max_y) + (pdvm_pkg::VP_W+1)'(vp.min_y);

  logic                         v2;
  logic signed [64:0]           px2, py2;
  logic signed [pdvm_pkg::DATA_W-1:0] dep2;
  logic                         satz2;
  pdvm_pkg::side_t              side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px2   <= diff_x * qx1;
      py2   <= diff_y * qy1;
      dep2  <= dep1;
      satz2 <= satz1;
      side2 <= side1;
    end
  end

  // halve, translate, saturate
  function automatic logic signed [64:0] place(input logic signed [64:0] p,
                                                input logic signed [pdvm_pkg::VP_W:0] s);
    logic signed [64:0] half;
    logic signed [64:0] trans;
    half  = (p + $signed(65'(p[64]))) >>> 1;
    trans = 65'(s) <<< (FB - 1);
    return trans + half;
  endfunction

  logic signed [64:0] tx, ty;
  logic               satx, saty;
  logic signed [pdvm_pkg::DATA_W-1:0] sx, sy;

  always_comb begin
    tx   = place(px2, sum_x);
    ty   = place(py2, sum_y);
    satx = (tx > 65'(SMAX)) || (tx < 65'(SMIN));
    saty = (ty > 65'(SMAX)) || (ty < 65'(SMIN));
    sx   = (tx > 65'(SMAX)) ? pdvm_pkg::DATA_W'(SMAX) :
           (tx < 65'(SMIN)) ? pdvm_pkg::DATA_W'(SMIN) : tx[pdvm_pkg::DATA_W-1:0];
    sy   = (ty > 65'(SMAX)) ? pdvm_pkg::DATA_W'(SMAX) :
           (ty < 65'(SMIN)) ? pdvm_pkg::DATA_W'(SMIN) : ty[pdvm_pkg::DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.screen_x <= sx;
      out_data.screen_y <= sy;
      out_data.depth    <= dep2;
      out_data.fault    <= side2.w_zero | satx | saty | satz2;
      out_data.slot_out <= side2.slot;
      out_data.last_out <= side2.last;
    end
  end

endmodule

>>> rtl/perspective_divide_viewport_map.sv
// ----------------------------------------------------------------------------
// perspective_divide_viewport_map
// Perspective divide of clip x, y, z by w and mapping of x, y into the
// viewport rectangle; saturated Q results with a fault flag.
// ----------------------------------------------------------------------------
//  channel  | signals                          | beat
//  ---------+----------------------------------+--------------------------
//  in       | in_valid, in_ready, in_data      | one clip-space vertex
//  out      | out_valid, out_ready, out_data   | one screen-space vertex
//  cfg      | cfg_wen, cfg_index, cfg_wdata    | one viewport register
//
// One beat per cycle sustained while the output is not stalled. The pipeline is
// an input register, the two-bit-per-stage divider and the map stages.
// Synchronous reset clears all valid bits and loads the default viewport.
// Stalls freeze the whole pipeline; in_ready is low only while a finished
// beat waits at the output.
module perspective_divide_viewport_map #(
  parameter int FRAC_BITS = pdvm_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pdvm_pkg::vtx_in_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pdvm_pkg::vtx_out_t            out_data,
  input  logic                          cfg_wen,
  input  logic [1:0]                    cfg_index,
  input  logic [pdvm_pkg::VP_W-1:0]     cfg_wdata
);

  localparam int DW = pdvm_pkg::DATA_W;
  localparam int NW = DW + FRAC_BITS;

  pdvm_pkg::viewport_t vp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp.min_x <= pdvm_pkg::VP_W'(0);
      vp.min_y <= pdvm_pkg::VP_W'(0);
      vp.max_x <= pdvm_pkg::VP_W'(1024);
      vp.max_y <= pdvm_pkg::VP_W'(1024);
    end else if (cfg_wen) begin
      case (pdvm_pkg::cfg_reg_e'(cfg_index))
        pdvm_pkg::REG_MIN_X: vp.min_x <= cfg_wdata;
        pdvm_pkg::REG_MIN_Y: vp.min_y <= cfg_wdata;
        pdvm_pkg::REG_MAX_X: vp.max_x <= cfg_wdata;
        pdvm_pkg::REG_MAX_Y: vp.max_y <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // input stage: magnitudes and signs
  logic                         v0;
  logic [pdvm_pkg::LANES-1:0][NW-1:0] num0;
  logic [DW-1:0]                den0;
  pdvm_pkg::side_t              side0;

  function automatic logic [DW-1:0] absv(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num0[0]        <= {absv(in_data.clip_x), {FRAC_BITS{1'b0}}};
      num0[1]        <= {absv(in_data.clip_y), {FRAC_BITS{1'b0}}};
      num0[2]        <= {absv(in_data.clip_z), {FRAC_BITS{1'b0}}};
      den0           <= absv(in_data.clip_w);
      side0.w_zero   <= (in_data.clip_w == '0);
      side0.num_neg  <= {in_data.clip_z[DW-1], in_data.clip_y[DW-1], in_data.clip_x[DW-1]};
      side0.num_nz   <= {in_data.clip_z != '0, in_data.clip_y != '0, in_data.clip_x != '0};
      side0.den_neg  <= in_data.clip_w[DW-1];
      side0.slot     <= in_data.vertex_slot;
      side0.last     <= in_data.last_vertex;
    end
  end

  logic                         dv;
  logic [pdvm_pkg::LANES-1:0][NW-1:0] dq;
  pdvm_pkg::side_t              dside;

  pdvm_div_pipe #(
    .NW(NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (v0),
    .num      (num0),
    .den      (den0),
    .side_in  (side0),
    .out_valid(dv),
    .quo      (dq),
    .side_out (dside)
  );

  pdvm_map #(
    .FB(FRAC_BITS),
    .NW(NW)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (dv),
    .quo      (dq),
    .side     (dside),
    .vp       (vp),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

>>> rtl/pdvm_checker.sv
// ----------------------------------------------------------------------------
// pdvm_checker
// Port-level checks for the perspective divide and viewport map.
// ----------------------------------------------------------------------------
module pdvm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input pdvm_pkg::vtx_out_t out_data
);

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  a_ready_track: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("in_ready low while output drains");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

endmodule

bind perspective_divide_viewport_map pdvm_checker u_pdvm_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

>>> tb/perspective_divide_viewport_map_tb.sv
// ----------------------------------------------------------------------------
// perspective_divide_viewport_map_tb
// Streams clip-space vertices through the perspective divide and viewport
// map under random idling and a long output stall, predicts every screen
// vertex in a scoreboard and compares it field by field in order.
// ----------------------------------------------------------------------------
module perspective_divide_viewport_map_tb;

  localparam longint QLIM = 64'sd1 << 48;
  localparam int     LAT  = 28;

  class vertex_scoreboard;
    longint             mnx, mny, mxx, mxy;
    pdvm_pkg::vtx_out_t pending[$];
    int                 errors;

    function new();
      mnx = 0; mny = 0; mxx = 1024; mxy = 1024; errors = 0;
    endfunction

    function void set_reg(pdvm_pkg::cfg_reg_e idx,
                          logic signed [pdvm_pkg::VP_W-1:0] v);
      case (idx)
        pdvm_pkg::REG_MIN_X: mnx = v;
        pdvm_pkg::REG_MIN_Y: mny = v;
        pdvm_pkg::REG_MAX_X: mxx = v;
        pdvm_pkg::REG_MAX_Y: mxy = v;
        default: ;
      endcase
    endfunction

    function longint divide(longint num, longint den);
      if (den == 0) return num > 0 ? QLIM : (num < 0 ? -QLIM : 0);
      return (num * 65536) / den;
    endfunction

    function logic [31:0] clamp32(longint v, ref logic flt);
      if (v > 64'sd2147483647) begin
        flt = 1; return 32'h7fffffff;
      end
      if (v < -64'sd2147483648) begin
        flt = 1; return 32'h80000000;
      end
      return v[31:0];
    endfunction

    function logic [31:0] axis(longint c, longint w, longint lo, longint hi,
                               ref logic flt);
      longint q;
      q = divide(c, w);
      if (q > QLIM) q = QLIM;
      if (q < -QLIM) q = -QLIM;
      return clamp32((hi + lo) * 32768 + ((hi - lo) * q) / 2, flt);
    endfunction

    function void note_vertex(pdvm_pkg::vtx_in_t v);
      pdvm_pkg::vtx_out_t e;
      logic               flt;
      longint             w;
      w = longint'(v.clip_w);
      flt = (w == 0);
      e.screen_x = axis(longint'(v.clip_x), w, mnx, mxx, flt);
      e.screen_y = axis(longint'(v.clip_y), w, mny, mxy, flt);
      e.depth    = clamp32(divide(longint'(v.clip_z), w), flt);
      e.fault    = flt;
      e.slot_out = v.vertex_slot;
      e.last_out = v.last_vertex;
      pending.insert(pending.size(), e);
    endfunction

    function void check_vertex(pdvm_pkg::vtx_out_t a);
      pdvm_pkg::vtx_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected beat %h", a); errors++; return;
      end
      e = pending.pop_front();
      if (a.screen_x !== e.screen_x) begin
        $error("screen_x exp %h got %h", e.screen_x, a.screen_x); errors++;
      end
      if (a.screen_y !== e.screen_y) begin
        $error("screen_y exp %h got %h", e.screen_y, a.screen_y); errors++;
      end
      if (a.depth !== e.depth) begin
        $error("depth exp %h got %h", e.depth, a.depth); errors++;
      end
      if (a.fault !== e.fault) begin
        $error("fault exp %b got %b", e.fault, a.fault); errors++;
      end
      if (a.slot_out !== e.slot_out) begin
        $error("slot_out exp %h got %h", e.slot_out, a.slot_out); errors++;
      end
      if (a.last_out !== e.last_out) begin
        $error("last_out exp %b got %b", e.last_out, a.last_out); errors++;
      end
    endfunction
  endclass

  logic                        clk = 0, rst = 1;
  logic                        in_valid = 0, in_ready, out_valid, out_ready = 0;
  pdvm_pkg::vtx_in_t           in_data = '0;
  pdvm_pkg::vtx_out_t          out_data;
  logic                        cfg_wen = 0;
  logic [1:0]                  cfg_index = '0;
  logic [pdvm_pkg::VP_W-1:0]   cfg_wdata = '0;
  int                          send_idle = 0, recv_idle = 0;
  logic                        hold = 0;
  vertex_scoreboard            sb = new();

  perspective_divide_viewport_map uut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_vertex(out_data);
    out_ready <= !hold && ($urandom_range(99) >= recv_idle);
  end

  task automatic stall_output(int cycles);
    hold <= 1;
    repeat (cycles) @(posedge clk);
    hold <= 0;
  endtask

  task automatic send_vertex(pdvm_pkg::vtx_in_t v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_vertex(v);
  endtask

  task automatic write_reg(pdvm_pkg::cfg_reg_e idx, logic [pdvm_pkg::VP_W-1:0] v);
    cfg_wen   <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(1) ? 32'h10000 : 32'hffff0000;
      4: return $signed($urandom_range(65535)) << $urandom_range(16);
      5: return $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  function automatic pdvm_pkg::vtx_in_t rand_vertex();
    pdvm_pkg::vtx_in_t v;
    v.clip_x = pick32();
    v.clip_y = pick32();
    v.clip_z = pick32();
    case ($urandom_range(9))
      0: v.clip_w = 0;
      1: v.clip_w = pick32();
      2: v.clip_w = $urandom_range(1) ? 32'sd1 : -32'sd1;
      default: v.clip_w = ($urandom_range(1) ? 1 : -1) *
                          $signed(32'($urandom_range(32'h7fffff, 32'h4000)));
    endcase
    v.vertex_slot = 4'($urandom);
    v.last_vertex = 1'($urandom);
    return v;
  endfunction

  task automatic load_window(int a, int b, int c, int d);
    write_reg(pdvm_pkg::REG_MIN_X, pdvm_pkg::VP_W'(a));
    write_reg(pdvm_pkg::REG_MIN_Y, pdvm_pkg::VP_W'(b));
    write_reg(pdvm_pkg::REG_MAX_X, pdvm_pkg::VP_W'(c));
    write_reg(pdvm_pkg::REG_MAX_Y, pdvm_pkg::VP_W'(d));
  endtask

  initial begin
    logic [31:0] ext[4];
    ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h10000};
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (ext[i]) begin
      send_vertex('{ext[i], ext[3-i], ext[(i+1)%4], 32'h10000, 4'hf, 1'b1});
      send_vertex('{ext[i], ext[(i+2)%4], ext[3-i], 32'h0, 4'h0, 1'b0});
      send_vertex('{ext[(i+1)%4], ext[i], ext[i], ext[i], 4'(i), 1'(i)});
    end
    send_vertex('{32'h0, 32'h0, 32'h0, 32'h0, 4'h5, 1'b1});
    send_vertex('{32'h8000, 32'hffff8000, 32'h4000, 32'h10000, 4'ha, 1'b0});
    drain();
    load_window(-8192, 8191, 8191, -8192);
    send_vertex('{32'h8000, 32'hffff8000, 32'h4000, 32'h10000, 4'h3, 1'b1});
    send_vertex('{32'h7fffffff, 32'h80000000, 32'h1, 32'h0, 4'hc, 1'b0});
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle = 13; recv_idle = 55; end
        1: begin send_idle = 55; recv_idle = 13; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (ph)
        0: load_window(0, 0, 1920, 1080);
        1: load_window(8191, 8191, -8192, -8192);
        2: load_window(-8192, -8192, 8191, 8191);
        3: load_window(100, 100, 100, 100);
        default: load_window($urandom, $urandom, $urandom, $urandom);
      endcase
      if (ph == 2) begin
        fork
          stall_output(200);
        join_none
      end
      repeat (325) send_vertex(rand_vertex());
      drain();
    end
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
